/* rtl/iml_pkg.sv */
// Shared constants, types and codes for the interval map range table.
package iml_pkg;

	localparam int ENTRIES    = 64;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 8;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int SPAN_W     = CNT_W + 1;

	localparam logic [2:0] ADDR_DEFAULT = 3'd0;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] val_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [SPAN_W-1:0]     span_t;

	typedef enum logic [1:0] {
		OP_ASSIGN = 2'd0,
		OP_LOOKUP = 2'd1
	} op_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_CALC,
		ST_DECIDE,
		ST_SHIFT,
		ST_INSERT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CAPTURE,
		CELL_PULL_HI,
		CELL_PULL_LO,
		CELL_LOAD
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		key_t      cmp_lt;
		key_t      cmp_le;
		key_t      ld_key;
		val_t      ld_val;
	} cell_ctrl_t;

	typedef struct packed {
		logic lt;
		logic le;
	} cell_flags_t;

endpackage

/* rtl/interval_map_range_table_unit.sv */
// Top level of the interval map range table: control sequencer and cell chain.
//
//  channel  | dir | fields (low bit up)
//  s_axis   | in  | tuser: operation; tdata: key_begin, key_end, new_value, lookup_key
//  m_axis   | out | tuser: status; tdata: read_value, entries_used
//  apb      | in  | reg 0 at 0x0: default_value
//
// A lookup, an empty assign and a full assign pass through the compare,
// calc and decide states to the result; any other assign then inserts, and
// first moves the tail of the table along the cell chain (up to ENTRIES
// positions) when needed, by the neighbor-to-neighbor shift of the cells.
// Reset empties the table; cell contents are not cleared.
// Input is taken only while the sequencer is idle; a waiting result holds
// the next one in its final state.
module interval_map_range_table_unit
	import iml_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // key_begin, key_end, new_value, lookup_key
	input  logic         s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata,  // read_value, entries_used, zero pad
	output logic         m_tuser,  // status
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	state_t state_q, state_d;
	val_t   default_q;
	cnt_t   n_q;
	logic   op_q;
	key_t   kb_q, ke_q, lk_q;
	val_t   nv_q;
	cnt_t   p_q, q_q;
	val_t   vprev_q, vend_q;
	logic   a_q, b_q, left_q, full_q;
	span_t  s_q, m_q;
	cnt_t   sh_q;
	logic   out_valid_q, out_status_q;
	val_t   out_read_q;
	cnt_t   out_used_q;

	cell_ctrl_t  ctrl  [ENTRIES];
	key_t        ckey  [ENTRIES];
	val_t        cval  [ENTRIES];
	cell_flags_t cflag [ENTRIES];

	// Configuration
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_DEFAULT) ? 32'(default_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= '0;
		end else if (psel && penable && pwrite && paddr == ADDR_DEFAULT) begin
			default_q <= pwdata[VALUE_BITS-1:0];
		end
	end

	// Cell chain
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		key_t lo_k, hi_k;
		val_t lo_v, hi_v;
		if (i == 0) begin : g_lo0
			assign lo_k = '0;
			assign lo_v = '0;
		end else begin : g_lo
			assign lo_k = ckey[i-1];
			assign lo_v = cval[i-1];
		end
		if (i == ENTRIES - 1) begin : g_hiN
			assign hi_k = '0;
			assign hi_v = '0;
		end else begin : g_hi
			assign hi_k = ckey[i+1];
			assign hi_v = cval[i+1];
		end
		iml_cell u_cell (
			.clk    (clk),
			.ctrl   (ctrl[i]),
			.valid  (CNT_W'(i) < n_q),
			.lo_key (lo_k),
			.lo_val (lo_v),
			.hi_key (hi_k),
			.hi_val (hi_v),
			.key    (ckey[i]),
			.val    (cval[i]),
			.flags  (cflag[i])
		);
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			ctrl[i].cmp_lt = kb_q;
			ctrl[i].cmp_le = (op_q == OP_LOOKUP[0]) ? lk_q : ke_q;
			ctrl[i].ld_key = kb_q;
			ctrl[i].ld_val = nv_q;
			ctrl[i].cmd    = CELL_HOLD;
			case (state_q)
				ST_CMP: ctrl[i].cmd = CELL_CAPTURE;
				ST_SHIFT: begin
					if (left_q && SPAN_W'(i) >= s_q)
						ctrl[i].cmd = CELL_PULL_HI;
					else if (!left_q && SPAN_W'(i) > SPAN_W'(p_q))
						ctrl[i].cmd = CELL_PULL_LO;
				end
				ST_INSERT: begin
					if (a_q && SPAN_W'(i) == SPAN_W'(p_q)) begin
						ctrl[i].cmd = CELL_LOAD;
					end else if (b_q && SPAN_W'(i) == SPAN_W'(p_q) + SPAN_W'(a_q)) begin
						ctrl[i].cmd    = CELL_LOAD;
						ctrl[i].ld_key = ke_q;
						ctrl[i].ld_val = vend_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Boundary of each thermometer gives its count and the value just below it
	cnt_t p_c, q_c;
	val_t vp_c, ve_c;
	always_comb begin
		logic nlt, nle;
		p_c  = '0;
		q_c  = '0;
		vp_c = '0;
		ve_c = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			nlt = (i == ENTRIES - 1) ? 1'b0 : cflag[(i+1) % ENTRIES].lt;
			nle = (i == ENTRIES - 1) ? 1'b0 : cflag[(i+1) % ENTRIES].le;
			if (cflag[i].lt && !nlt) begin
				p_c  = p_c | CNT_W'(i + 1);
				vp_c = vp_c | cval[i];
			end
			if (cflag[i].le && !nle) begin
				q_c  = q_c | CNT_W'(i + 1);
				ve_c = ve_c | cval[i];
			end
		end
		if (p_c == '0) vp_c = default_q;
		if (q_c == '0) ve_c = default_q;
	end

	logic  a_c, b_c;
	span_t s_c, m_c;
	always_comb begin
		a_c = (nv_q != vprev_q);
		b_c = (vend_q != nv_q);
		s_c = SPAN_W'(p_q) + SPAN_W'(a_c) + SPAN_W'(b_c);
		m_c = s_c + SPAN_W'(n_q) - SPAN_W'(q_q);
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_CMP;
			ST_CMP:    state_d = ST_CALC;
			ST_CALC:   state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (op_q == OP_LOOKUP[0] || kb_q >= ke_q || m_c > SPAN_W'(ENTRIES))
					state_d = ST_DONE;
				else if (SPAN_W'(q_q) != s_c)
					state_d = ST_SHIFT;
				else
					state_d = ST_INSERT;
			end
			ST_SHIFT:  if (sh_q == CNT_W'(1)) state_d = ST_INSERT;
			ST_INSERT: state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			sh_q        <= '0;
			full_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_DECIDE: begin
					full_q <= (op_q == OP_ASSIGN[0]) && (kb_q < ke_q)
						&& (m_c > SPAN_W'(ENTRIES));
					if (SPAN_W'(q_q) > s_c) sh_q <= CNT_W'(SPAN_W'(q_q) - s_c);
					else                    sh_q <= CNT_W'(s_c - SPAN_W'(q_q));
				end
				ST_SHIFT:  sh_q <= sh_q - CNT_W'(1);
				ST_INSERT: n_q  <= CNT_W'(m_q);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q <= s_tuser;
			kb_q <= s_tdata[31:0];
			ke_q <= s_tdata[63:32];
			nv_q <= s_tdata[71:64];
			lk_q <= s_tdata[103:72];
		end
		if (state_q == ST_CALC) begin
			p_q     <= p_c;
			q_q     <= q_c;
			vprev_q <= vp_c;
			vend_q  <= ve_c;
		end
		if (state_q == ST_DECIDE) begin
			a_q    <= a_c;
			b_q    <= b_c;
			s_q    <= s_c;
			m_q    <= m_c;
			left_q <= SPAN_W'(q_q) > s_c;
		end
		if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_read_q   <= (op_q == OP_LOOKUP[0]) ? vend_q : '0;
			out_status_q <= full_q;
			out_used_q   <= n_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {1'b0, out_used_q, out_read_q};

endmodule

/* rtl/iml_cell.sv */
// One breakpoint cell: holds a key and value, compares, and shifts to neighbors.
module iml_cell
	import iml_pkg::*;
(
	input  logic        clk,
	input  cell_ctrl_t  ctrl,
	input  logic        valid,
	input  key_t        lo_key,
	input  val_t        lo_val,
	input  key_t        hi_key,
	input  val_t        hi_val,
	output key_t        key,
	output val_t        val,
	output cell_flags_t flags
);

	key_t        key_q;
	val_t        val_q;
	cell_flags_t flags_q;

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CELL_CAPTURE: begin
				flags_q.lt <= valid && (key_q < ctrl.cmp_lt);
				flags_q.le <= valid && (key_q <= ctrl.cmp_le);
			end
			CELL_PULL_HI: begin
				key_q <= hi_key;
				val_q <= hi_val;
			end
			CELL_PULL_LO: begin
				key_q <= lo_key;
				val_q <= lo_val;
			end
			CELL_LOAD: begin
				key_q <= ctrl.ld_key;
				val_q <= ctrl.ld_val;
			end
			default: begin
			end
		endcase
	end

	assign key   = key_q;
	assign val   = val_q;
	assign flags = flags_q;

endmodule

/* sim/interval_map_range_table_checker.sv */
// Checker for the interval map range table: predicts each result and compares it.
`timescale 1ns / 100ps

module interval_map_range_table_checker
	import iml_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [15:0]  m_tdata,
	input  logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		val_t read_value;
		logic status;
		cnt_t entries_used;
	} range_result_t;

	val_t          fill_value;
	key_t          bp_key [ENTRIES];
	val_t          bp_val [ENTRIES];
	int            bp_count;
	range_result_t expected_results [$];

	assign pending = expected_results.size();

	function automatic val_t value_at_key(key_t k);
		val_t v;
		v = fill_value;
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] <= k) v = bp_val[i];
			else break;
		end
		return v;
	endfunction

	// Rebuild the table for one assign; return 1 when it would overflow.
	function automatic logic apply_assign(key_t kb, key_t ke, val_t nv);
		key_t nk [ENTRIES+2];
		val_t nval [ENTRIES+2];
		int   m;
		int   i;
		val_t v_prev;
		val_t v_end;
		m = 0;
		i = 0;
		v_prev = fill_value;
		if (kb >= ke) return 1'b0;
		v_end = value_at_key(ke);
		while (i < bp_count && bp_key[i] < kb) begin
			nk[m] = bp_key[i];
			nval[m] = bp_val[i];
			v_prev = bp_val[i];
			m++;
			i++;
		end
		if (nv != v_prev) begin
			nk[m] = kb;
			nval[m] = nv;
			m++;
		end
		while (i < bp_count && bp_key[i] <= ke) i++;
		if (v_end != nv) begin
			nk[m] = ke;
			nval[m] = v_end;
			m++;
		end
		if (m + (bp_count - i) > ENTRIES) return 1'b1;
		while (i < bp_count) begin
			nk[m] = bp_key[i];
			nval[m] = bp_val[i];
			m++;
			i++;
		end
		for (int j = 0; j < m; j++) begin
			bp_key[j] = nk[j];
			bp_val[j] = nval[j];
		end
		bp_count = m;
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		range_result_t exp_r;
		range_result_t got;
		if (!arst_n) begin
			fill_value = '0;
			bp_count = 0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (psel && penable && pwrite && paddr == ADDR_DEFAULT)
				fill_value = pwdata[VALUE_BITS-1:0];
			if (m_tvalid && m_tready) begin
				got.read_value = m_tdata[7:0];
				got.entries_used = m_tdata[8 +: CNT_W];
				got.status = m_tuser;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.read_value !== exp_r.read_value) begin
						$display("%0t: read_value expected %h actual %h", $time,
							exp_r.read_value, got.read_value);
						fail_count++;
					end
					if (got.status !== exp_r.status) begin
						$display("%0t: status expected %h actual %h", $time,
							exp_r.status, got.status);
						fail_count++;
					end
					if (got.entries_used !== exp_r.entries_used) begin
						$display("%0t: entries_used expected %0d actual %0d", $time,
							exp_r.entries_used, got.entries_used);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				exp_r = '0;
				if (s_tuser == OP_LOOKUP[0])
					exp_r.read_value = value_at_key(s_tdata[103:72]);
				else
					exp_r.status = apply_assign(s_tdata[31:0], s_tdata[63:32],
						s_tdata[71:64]);
				exp_r.entries_used = cnt_t'(bp_count);
				expected_results.push_back(exp_r);
			end
		end
	end

endmodule

/* sim/interval_map_range_table_unit_test.sv */
// Testbench top for the interval map range table: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module interval_map_range_table_unit_test;
	import iml_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;  // key_begin, key_end, new_value, lookup_key
	logic         s_tuser;  // operation
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;  // read_value, entries_used, zero pad
	logic         m_tuser;  // status
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	int           fail_count;
	int           pending;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           hold_off;
	longint       cycle_count;

	interval_map_range_table_unit DUT (.*);

	interval_map_range_table_checker range_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Receiver: random stalls plus an optional long hold-off.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				hold_off--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic write_default(input val_t v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_DEFAULT;
		pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_request(input logic op, input key_t kb, input key_t ke,
		input val_t nv, input key_t lk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {lk, nv, ke, kb};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// Keys drawn from a narrow window so intervals overlap; sometimes full range.
	function automatic key_t pick_key(input int spread);
		if ($urandom_range(9) == 0) return key_t'($urandom());
		return key_t'($urandom_range(spread));
	endfunction

	task automatic random_items(input int count, input int spread);
		key_t a;
		key_t b;
		for (int i = 0; i < count; i++) begin
			a = pick_key(spread);
			b = pick_key(spread);
			if ($urandom_range(3) != 0 && a > b) {a, b} = {b, a};
			if ($urandom_range(1))
				send_request(OP_ASSIGN[0], a, b, val_t'($urandom_range(7)),
					key_t'($urandom()));
			else
				send_request(OP_LOOKUP[0], key_t'($urandom()), key_t'($urandom()),
					val_t'($urandom()), pick_key(spread));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, empty interval, reversed, canonical merges.
		send_request(OP_LOOKUP[0], '0, '0, '0, '0);
		send_request(OP_ASSIGN[0], 32'd10, 32'd20, 8'd5, '0);
		send_request(OP_ASSIGN[0], 32'd20, 32'd20, 8'd9, '0);
		send_request(OP_ASSIGN[0], 32'd30, 32'd25, 8'd9, '0);
		send_request(OP_ASSIGN[0], 32'd20, 32'd30, 8'd5, '0);
		send_request(OP_ASSIGN[0], 32'd15, 32'd18, 8'd0, '0);
		send_request(OP_ASSIGN[0], '0, '1, 8'hFF, '0);
		send_request(OP_LOOKUP[0], '1, '1, '1, '1);
		send_request(OP_LOOKUP[0], '0, '0, '0, 32'hFFFF_FFFE);
		send_request(OP_ASSIGN[0], '0, '1, 8'h00, '1);
		send_request(OP_ASSIGN[0], 32'h8000_0000, '1, 8'hAA, '0);
		send_request(OP_LOOKUP[0], '0, '0, '0, 32'h7FFF_FFFF);
		send_request(OP_LOOKUP[0], '0, '0, '0, 32'h8000_0000);
		// Fill the table to overflow with alternating values.
		for (int i = 0; i < 36; i++)
			send_request(OP_ASSIGN[0], key_t'(4 * i), key_t'(4 * i + 2),
				val_t'(i + 1), '0);
		drain();
		write_default(8'hFF);
		send_request(OP_LOOKUP[0], '0, '0, '0, '0);
		send_request(OP_ASSIGN[0], '0, 32'd3, 8'hFF, '0);
		drain();
		write_default(8'h00);
		send_request(OP_ASSIGN[0], '0, '1, 8'h00, '0);

		send_idle_pct = 18;
		recv_idle_pct = 79;
		random_items(170, 60);
		drain();
		write_default(8'h03);
		send_idle_pct = 79;
		recv_idle_pct = 18;
		random_items(160, 400);
		drain();
		write_default(8'h00);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off = 300;
		random_items(170, 30);
		drain();

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
